[hdl/lrpq_pkg.sv]
// Package for the layer request priority queue.
// Holds the queue sizes, command and status codes, and the controller types.
// No dependencies.
package lrpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int LAYER_W = 6;
  localparam int PRIO_W  = 8;
  localparam int TICK_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_ZERO = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic res_pending;
  } sts_t;

endpackage

[hdl/lrpq_ctrl.sv]
// Controller state machine of the layer request priority queue.
// Sequences capture and execution of one beat; depends on lrpq_pkg.
module lrpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  input  lrpq_pkg::sts_t    sts,
  output logic              in_stall,
  output lrpq_pkg::ctl_t    ctl
);

  lrpq_pkg::state_t state;
  lrpq_pkg::state_t state_next;

  always_comb begin
    ctl.load   = 1'b0;
    ctl.exec   = 1'b0;
    in_stall   = 1'b1;
    state_next = state;
    case (state)
      lrpq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = lrpq_pkg::ST_EXEC;
        end
      end
      lrpq_pkg::ST_EXEC: begin
        // hold until the result register is free
        if (!sts.res_pending || !out_stall) begin
          ctl.exec   = 1'b1;
          state_next = lrpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/lrpq_dp.sv]
// Datapath of the layer request priority queue: row of entry cells,
// fill count, captured beat and result register; depends on lrpq_pkg.
module lrpq_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  lrpq_pkg::ctl_t                   ctl,
  output lrpq_pkg::sts_t                   sts,
  input  logic [lrpq_pkg::CMD_W-1:0]       command,
  input  logic [lrpq_pkg::ID_W-1:0]        task_id,
  input  logic [lrpq_pkg::LAYER_W-1:0]     layer_index,
  input  logic [lrpq_pkg::PRIO_W-1:0]      prio,
  input  logic [lrpq_pkg::TICK_W-1:0]      now_tick,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [lrpq_pkg::STAT_W-1:0]      status,
  output logic [lrpq_pkg::ID_W-1:0]        out_id,
  output logic [lrpq_pkg::LAYER_W-1:0]     out_layer,
  output logic [lrpq_pkg::TICK_W-1:0]      start_tick,
  output logic [lrpq_pkg::CNT_W-1:0]       occupancy
);

  localparam int QD = lrpq_pkg::QUEUE_DEPTH;

  logic [lrpq_pkg::CMD_W-1:0]   cmd_q;
  logic [lrpq_pkg::ID_W-1:0]    id_q;
  logic [lrpq_pkg::LAYER_W-1:0] layer_q;
  logic [lrpq_pkg::PRIO_W-1:0]  prio_q;
  logic [lrpq_pkg::TICK_W-1:0]  tick_q;

  logic [lrpq_pkg::ID_W-1:0]    ent_id         [QD];
  logic [lrpq_pkg::LAYER_W-1:0] ent_layer      [QD];
  logic [lrpq_pkg::PRIO_W-1:0]  ent_prio       [QD];
  logic [lrpq_pkg::ID_W-1:0]    ent_id_next    [QD];
  logic [lrpq_pkg::LAYER_W-1:0] ent_layer_next [QD];
  logic [lrpq_pkg::PRIO_W-1:0]  ent_prio_next  [QD];
  logic [lrpq_pkg::CNT_W-1:0]   fill;
  logic [lrpq_pkg::CNT_W-1:0]   fill_next;

  logic [QD-1:0]                live;
  logic [QD-1:0]                ins_pre;
  logic [QD-1:0]                hit;
  logic [QD-1:0]                rm_pre;
  logic [QD-1:0]                rm_sel;
  logic                         ins_at_head;
  logic                         found;
  logic [lrpq_pkg::ID_W-1:0]    rm_id;
  logic [lrpq_pkg::LAYER_W-1:0] rm_layer;

  logic                         res_valid;
  logic [lrpq_pkg::STAT_W-1:0]  stat_next;
  logic [lrpq_pkg::ID_W-1:0]    oid_next;
  logic [lrpq_pkg::LAYER_W-1:0] olayer_next;
  logic [lrpq_pkg::TICK_W-1:0]  otick_next;

  // per-cell compares and position chains
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      live[i] = lrpq_pkg::CNT_W'(i) < fill;
      hit[i]  = (cmd_q == lrpq_pkg::CMD_POP_ZERO) && live[i] && (ent_layer[i] == '0);
    end
    found       = |hit;
    ins_at_head = (fill == '0) || (ent_prio[0] > prio_q);
    ins_pre[0]  = !ins_at_head;
    rm_pre[0]   = found && !hit[0];
    for (int i = 1; i < QD; i++) begin
      ins_pre[i] = ins_pre[i-1] && live[i] && (ent_prio[i] < prio_q);
      rm_pre[i]  = rm_pre[i-1] && !hit[i];
    end
    rm_sel[0] = !rm_pre[0];
    for (int i = 1; i < QD; i++) begin
      rm_sel[i] = !rm_pre[i] && rm_pre[i-1];
    end
    rm_id    = '0;
    rm_layer = '0;
    for (int i = 0; i < QD; i++) begin
      rm_id    = rm_id    | (ent_id[i]    & {lrpq_pkg::ID_W{rm_sel[i]}});
      rm_layer = rm_layer | (ent_layer[i] & {lrpq_pkg::LAYER_W{rm_sel[i]}});
    end
  end

  always_comb begin
    ent_id_next    = ent_id;
    ent_layer_next = ent_layer;
    ent_prio_next  = ent_prio;
    fill_next      = fill;
    stat_next      = lrpq_pkg::STAT_DONE;
    oid_next       = '0;
    olayer_next    = '0;
    otick_next     = '0;
    case (cmd_q)
      lrpq_pkg::CMD_INSERT: begin
        if (fill == lrpq_pkg::CNT_W'(QD)) begin
          stat_next = lrpq_pkg::STAT_FULL;
        end else begin
          fill_next = fill + 1'b1;
          for (int i = 0; i < QD; i++) begin
            if (!ins_pre[i]) begin
              if (i == 0 || ins_pre[(i == 0) ? 0 : i-1]) begin
                ent_id_next[i]    = id_q;
                ent_layer_next[i] = layer_q;
                ent_prio_next[i]  = prio_q;
              end else begin
                ent_id_next[i]    = ent_id[(i == 0) ? 0 : i-1];
                ent_layer_next[i] = ent_layer[(i == 0) ? 0 : i-1];
                ent_prio_next[i]  = ent_prio[(i == 0) ? 0 : i-1];
              end
            end
          end
        end
      end
      lrpq_pkg::CMD_POP_HEAD, lrpq_pkg::CMD_POP_ZERO: begin
        if (fill == '0) begin
          stat_next = lrpq_pkg::STAT_EMPTY;
        end else begin
          fill_next   = fill - 1'b1;
          oid_next    = rm_id;
          olayer_next = rm_layer;
          otick_next  = tick_q;
          for (int i = 0; i < QD - 1; i++) begin
            if (!rm_pre[i]) begin
              ent_id_next[i]    = ent_id[i+1];
              ent_layer_next[i] = ent_layer[i+1];
              ent_prio_next[i]  = ent_prio[i+1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= command;
      id_q    <= task_id;
      layer_q <= layer_index;
      prio_q  <= prio;
      tick_q  <= now_tick;
    end
    if (ctl.exec) begin
      ent_id     <= ent_id_next;
      ent_layer  <= ent_layer_next;
      ent_prio   <= ent_prio_next;
      status     <= stat_next;
      out_id     <= oid_next;
      out_layer  <= olayer_next;
      start_tick <= otick_next;
      occupancy  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (ctl.exec) begin
        fill      <= fill_next;
        res_valid <= 1'b1;
      end else if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign out_valid       = res_valid;
  assign sts.res_pending = res_valid;

endmodule

[hdl/layer_request_priority_queue.sv]
// Top level of the layer request priority queue.
// Joins lrpq_ctrl and lrpq_dp; depends on lrpq_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | command task_id layer_index prio now_tick
//  out     | out_valid / out_stall| status out_id out_layer start_tick occupancy
//
// Each beat is captured, then executed: all entry cells compare in parallel
// and the cell row shifts in place.
// Execute waits while a previous result is still held on the output.
// Reset empties the queue at once; entry contents need no clearing.
// A new beat is accepted while a finished result waits to be taken.
module layer_request_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrpq_pkg::CMD_W-1:0]    command,
  input  logic [lrpq_pkg::ID_W-1:0]     task_id,
  input  logic [lrpq_pkg::LAYER_W-1:0]  layer_index,
  input  logic [lrpq_pkg::PRIO_W-1:0]   prio,
  input  logic [lrpq_pkg::TICK_W-1:0]   now_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrpq_pkg::STAT_W-1:0]   status,
  output logic [lrpq_pkg::ID_W-1:0]     out_id,
  output logic [lrpq_pkg::LAYER_W-1:0]  out_layer,
  output logic [lrpq_pkg::TICK_W-1:0]   start_tick,
  output logic [lrpq_pkg::CNT_W-1:0]    occupancy
);

  lrpq_pkg::ctl_t ctl;
  lrpq_pkg::sts_t sts;

  lrpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .ctl       (ctl)
  );

  lrpq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .task_id     (task_id),
    .layer_index (layer_index),
    .prio        (prio),
    .now_tick    (now_tick),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .out_id      (out_id),
    .out_layer   (out_layer),
    .start_tick  (start_tick),
    .occupancy   (occupancy)
  );

endmodule

[test/layer_request_priority_queue_test.sv]
// Self-checking testbench for layer_request_priority_queue.
// Uses a directed and random request stream, a shadow queue for prediction and random idling.
// Depends on lrpq_pkg and the layer_request_priority_queue RTL.
`timescale 1ns / 100ps

module layer_request_priority_queue_test;
  import lrpq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [LAYER_W-1:0] layer;
    logic [PRIO_W-1:0]  prio;
    logic [TICK_W-1:0]  tick;
    bit                 drain;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    id;
    logic [LAYER_W-1:0] layer;
    logic [TICK_W-1:0]  tick;
    logic [CNT_W-1:0]   occupancy;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = '0;
  logic [ID_W-1:0]     task_id = '0;
  logic [LAYER_W-1:0]  layer_index = '0;
  logic [PRIO_W-1:0]   prio = '0;
  logic [TICK_W-1:0]   now_tick = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     out_id;
  logic [LAYER_W-1:0]  out_layer;
  logic [TICK_W-1:0]   start_tick;
  logic [CNT_W-1:0]    occupancy;

  request_t request_fifo[$];
  outcome_t outcome_fifo[$];

  logic [ID_W-1:0]    shadow_id[QUEUE_DEPTH];
  logic [LAYER_W-1:0] shadow_layer[QUEUE_DEPTH];
  logic [PRIO_W-1:0]  shadow_prio[QUEUE_DEPTH];
  int                 shadow_fill = 0;

  bit in_took = 1'b0;
  int accepted_beats = 0;
  int idle_cycles = 0;
  int errors = 0;
  logic calm;

  assign calm = (accepted_beats >= 300) && (accepted_beats < 520);

  layer_request_priority_queue i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .task_id     (task_id),
    .layer_index (layer_index),
    .prio        (prio),
    .now_tick    (now_tick),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_id      (out_id),
    .out_layer   (out_layer),
    .start_tick  (start_tick),
    .occupancy   (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t serve_request(request_t r);
    outcome_t o;
    int slot;
    int i;
    o.status = STAT_DONE;
    o.id = '0;
    o.layer = '0;
    o.tick = '0;
    case (r.cmd)
      CMD_INSERT: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          if (shadow_fill == 0 || shadow_prio[0] > r.prio) begin
            slot = 0;
          end else begin
            slot = 1;
            while (slot < shadow_fill && shadow_prio[slot] < r.prio) slot++;
          end
          for (i = shadow_fill; i > slot; i--) begin
            shadow_id[i] = shadow_id[i-1];
            shadow_layer[i] = shadow_layer[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_id[slot] = r.id;
          shadow_layer[slot] = r.layer;
          shadow_prio[slot] = r.prio;
          shadow_fill++;
        end
      end
      CMD_POP_HEAD, CMD_POP_ZERO: begin
        if (shadow_fill == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          slot = 0;
          if (r.cmd == CMD_POP_ZERO) begin
            for (i = shadow_fill - 1; i >= 0; i--) begin
              if (shadow_layer[i] == '0) slot = i;
            end
          end
          o.id = shadow_id[slot];
          o.layer = shadow_layer[slot];
          o.tick = r.tick;
          for (i = slot; i + 1 < shadow_fill; i++) begin
            shadow_id[i] = shadow_id[i+1];
            shadow_layer[i] = shadow_layer[i+1];
            shadow_prio[i] = shadow_prio[i+1];
          end
          shadow_fill--;
        end
      end
      default: ;
    endcase
    o.occupancy = CNT_W'(shadow_fill);
    return o;
  endfunction

  // Drive beats at the falling edge; hold a stalled beat.
  always @(negedge clk) begin
    request_t beat_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (request_fifo.size() > 0 && (calm || $urandom_range(0, 99) >= 10) &&
          !(request_fifo[0].drain && outcome_fifo.size() > 0)) begin
        beat_req = request_fifo.pop_front();
        in_valid <= 1'b1;
        command <= beat_req.cmd;
        task_id <= beat_req.id;
        layer_index <= beat_req.layer;
        prio <= beat_req.prio;
        now_tick <= beat_req.tick;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    request_t seen;
    outcome_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        seen.cmd = command;
        seen.id = task_id;
        seen.layer = layer_index;
        seen.prio = prio;
        seen.tick = now_tick;
        seen.drain = 1'b0;
        outcome_fifo.push_back(serve_request(seen));
        accepted_beats++;
      end
      if (out_valid && !out_stall) begin
        if (outcome_fifo.size() == 0) begin
          if (errors < 10) $display("unexpected result beat: status %0d id %0d layer %0d",
                                    status, out_id, out_layer);
          errors++;
        end else begin
          want = outcome_fifo.pop_front();
          if (status !== want.status || out_id !== want.id || out_layer !== want.layer ||
              start_tick !== want.tick || occupancy !== want.occupancy) begin
            if (errors < 10) begin
              $display("mismatch: status %0d/%0d id %0d/%0d layer %0d/%0d (expected/actual)",
                       want.status, status, want.id, out_id, want.layer, out_layer);
              $display("          tick %0h/%0h occupancy %0d/%0d",
                       want.tick, start_tick, want.occupancy, occupancy);
            end
            errors++;
          end
        end
      end
      if (in_took || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [LAYER_W-1:0] layer, input logic [PRIO_W-1:0] p,
                             input logic [TICK_W-1:0] tick, input bit drain);
    request_t r;
    r.cmd = cmd;
    r.id = id;
    r.layer = layer;
    r.prio = p;
    r.tick = tick;
    r.drain = drain;
    request_fifo.push_back(r);
  endtask

  initial begin
    logic [PRIO_W-1:0]  fill_prio[16];
    logic [ID_W-1:0]    fill_id[16];
    logic [LAYER_W-1:0] fill_layer[16];
    int mode;
    int insert_pct;
    int roll;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [LAYER_W-1:0] layer;
    logic [PRIO_W-1:0]  p;

    fill_prio = '{8'd255, 8'd0, 8'd0, 8'd128, 8'd7, 8'd128, 8'd255, 8'd3,
                  8'd200, 8'd0, 8'd64, 8'd64, 8'd9, 8'd255, 8'd1, 8'd128};
    fill_id = '{8'd255, 8'd0, 8'd17, 8'd17, 8'd42, 8'd42, 8'd42, 8'd99,
                8'd5, 8'd5, 8'd255, 8'd0, 8'd17, 8'd8, 8'd42, 8'd3};
    fill_layer = '{6'd63, 6'd0, 6'd12, 6'd0, 6'd5, 6'd63, 6'd0, 6'd1,
                   6'd2, 6'd3, 6'd0, 6'd40, 6'd63, 6'd7, 6'd0, 6'd31};

    add_request(CMD_POP_HEAD, 8'hFF, 6'h3F, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_request(CMD_POP_ZERO, 8'h00, 6'h00, 8'h00, 32'h1234_5678, 1'b0);
    add_request(CMD_UNUSED, 8'hAA, 6'h2A, 8'h55, 32'hDEAD_BEEF, 1'b0);
    for (int k = 0; k < 16; k++) begin
      add_request(CMD_INSERT, fill_id[k], fill_layer[k], fill_prio[k], $urandom, 1'b0);
    end
    add_request(CMD_INSERT, 8'd77, 6'd0, 8'd0, 32'h0, 1'b0);
    add_request(CMD_UNUSED, 8'h55, 6'h15, 8'hAA, 32'h0, 1'b0);
    add_request(CMD_POP_ZERO, 8'h00, 6'h00, 8'h00, 32'h0000_0000, 1'b0);
    add_request(CMD_POP_ZERO, 8'h00, 6'h00, 8'h00, 32'hFFFF_FFFF, 1'b0);
    add_request(CMD_POP_HEAD, 8'h00, 6'h00, 8'h00, 32'h8000_0001, 1'b0);
    add_request(CMD_POP_ZERO, 8'h00, 6'h00, 8'h00, 32'h7FFF_FFFE, 1'b0);

    mode = 0;
    for (int n = 0; n < 1200; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      insert_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = CMD_UNUSED;
      else if ($urandom_range(0, 99) < insert_pct) cmd = CMD_INSERT;
      else if ($urandom_range(0, 1)) cmd = CMD_POP_HEAD;
      else cmd = CMD_POP_ZERO;
      id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
      layer = ($urandom_range(0, 9) < 3) ? '0 : LAYER_W'($urandom_range(0, 63));
      roll = $urandom_range(0, 9);
      if (roll < 4) p = PRIO_W'($urandom_range(0, 7));
      else if (roll == 4) p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else p = PRIO_W'($urandom_range(0, 255));
      add_request(cmd, id, layer, p, $urandom,
                  (n == 600) || ($urandom_range(0, 99) == 0));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_fifo.size() > 0 || in_valid || outcome_fifo.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lrpq_pkg.sv
hdl/lrpq_ctrl.sv
hdl/lrpq_dp.sv
hdl/layer_request_priority_queue.sv
test/layer_request_priority_queue_test.sv
